### rtl/hrv_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package hrv_pkg;

    // Field widths
    localparam int unsigned IV_W     = 12;
    localparam int unsigned SQ_W     = 2 * IV_W;
    localparam int unsigned SUM_W    = 36;
    localparam int unsigned KEPT_W   = 13;
    localparam int unsigned RMSSD_W  = 16;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned CFG_W    = 12;
    localparam int unsigned CFG_A_W  = 1;

    // sum * 256 gives Q.4 after the root
    localparam int unsigned FRAC_SH  = 8;
    localparam int unsigned QUO_W    = SUM_W + FRAC_SH;
    localparam int unsigned ROOT_W   = QUO_W / 2;

    localparam int unsigned MAX_INTERVALS_DEF = 4096;

    localparam logic [CFG_W-1:0] MIN_IV_RESET = CFG_W'(300);
    localparam logic [CFG_W-1:0] MAX_IV_RESET = CFG_W'(2000);
    localparam int unsigned      MIN_KEPT     = 3;

    localparam logic [CFG_A_W-1:0] CFG_MIN_IDX = 1'b0;
    localparam logic [CFG_A_W-1:0] CFG_MAX_IDX = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_VALID    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FEW      = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_OVERFLOW = 2'd2;

    // Sequencer strobes into the window accumulator
    typedef struct packed {
        logic load;
        logic square;
        logic add;
        logic clear;
    } acc_ctrl_t;

endpackage

`default_nettype wire

### rtl/hrv_accum.sv
`timescale 1ns / 1ps
`default_nettype none

module hrv_accum
    import hrv_pkg::*;
#(
    parameter int unsigned MAX_INTERVALS = MAX_INTERVALS_DEF,
    parameter int unsigned CNT_W         = $clog2(MAX_INTERVALS + 2)
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire acc_ctrl_t        ctrl,
    input  wire logic [IV_W-1:0]  interval_ms,
    input  wire logic [CFG_W-1:0] min_iv,
    input  wire logic [CFG_W-1:0] max_iv,
    output logic [CNT_W-1:0]      kept,
    output logic [SUM_W-1:0]      sum,
    output logic                  overflowed
);

    logic [IV_W-1:0]  iv_reg;
    logic [SQ_W-1:0]  sq_reg;
    logic             in_range_reg;
    logic [IV_W-1:0]  prev_reg;
    logic             have_prev_reg;
    logic [CNT_W-1:0] kept_reg;
    logic [SUM_W-1:0] sum_reg;
    logic             ovf_reg;
    logic             add_pend_reg;

    logic [IV_W-1:0]  diff;
    logic [SUM_W:0]   sum_ext;

    assign diff    = (iv_reg >= prev_reg) ? (iv_reg - prev_reg) : (prev_reg - iv_reg);
    assign sum_ext = {1'b0, sum_reg} + (SUM_W + 1)'(sq_reg);

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            iv_reg <= interval_ms;
        end
        if (ctrl.square)
        begin
            sq_reg <= diff * diff;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_range_reg  <= 1'b0;
            prev_reg      <= '0;
            have_prev_reg <= 1'b0;
            kept_reg      <= '0;
            sum_reg       <= '0;
            ovf_reg       <= 1'b0;
            add_pend_reg  <= 1'b0;
        end
        else
        begin
            priority if (ctrl.clear)
            begin
                prev_reg      <= '0;
                have_prev_reg <= 1'b0;
                kept_reg      <= '0;
                sum_reg       <= '0;
                ovf_reg       <= 1'b0;
                add_pend_reg  <= 1'b0;
            end
            else if (ctrl.load)
            begin
                in_range_reg <= (interval_ms >= min_iv) && (interval_ms <= max_iv);
            end
            else if (ctrl.square)
            begin
                add_pend_reg <= 1'b0;
                if (in_range_reg && !ovf_reg)
                begin
                    kept_reg <= kept_reg + CNT_W'(1);
                    if (kept_reg == CNT_W'(MAX_INTERVALS))
                    begin
                        // count stops at MAX_INTERVALS + 1, window frozen
                        ovf_reg <= 1'b1;
                    end
                    else
                    begin
                        add_pend_reg  <= have_prev_reg;
                        prev_reg      <= iv_reg;
                        have_prev_reg <= 1'b1;
                    end
                end
            end
            else if (ctrl.add)
            begin
                if (add_pend_reg)
                begin
                    sum_reg <= sum_ext[SUM_W] ? {SUM_W{1'b1}} : sum_ext[SUM_W-1:0];
                end
                add_pend_reg <= 1'b0;
            end
        end
    end

    assign kept       = kept_reg;
    assign sum        = sum_reg;
    assign overflowed = ovf_reg;

endmodule

`default_nettype wire

### rtl/hrv_divsqrt.sv
`timescale 1ns / 1ps
`default_nettype none

// Restoring divide of (sum << 8) by the divisor, then a bit-pair square root of
// the quotient. Both phases share one subtractor and the quotient shift register.
module hrv_divsqrt
    import hrv_pkg::*;
#(
    parameter int unsigned CNT_W = $clog2(MAX_INTERVALS_DEF + 2)
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               go,
    input  wire logic [SUM_W-1:0]   dividend,
    input  wire logic [CNT_W-1:0]   divisor,
    output logic                    done,
    output logic [RMSSD_W-1:0]      root
);

    localparam int unsigned DIV_SUB_W = CNT_W + 1;
    localparam int unsigned SQ_SUB_W  = ROOT_W + 2;
    localparam int unsigned SUB_W     = (DIV_SUB_W > SQ_SUB_W) ? DIV_SUB_W : SQ_SUB_W;
    localparam int unsigned STEP_W    = $clog2(QUO_W + 1);

    typedef enum logic [1:0] {
        R_IDLE,
        R_DIV,
        R_SQRT
    } rstate_t;

    rstate_t            state_reg;
    logic [QUO_W-1:0]   q_reg;
    logic [SUB_W-1:0]   rem_reg;
    logic [CNT_W-1:0]   dsr_reg;
    logic [ROOT_W-1:0]  root_reg;
    logic [STEP_W-1:0]  step_reg;
    logic               done_reg;

    logic [SUB_W-1:0]   a_op;
    logic [SUB_W-1:0]   b_op;
    logic [SUB_W:0]     diff;
    logic               fits;

    always_comb
    begin
        if (state_reg == R_SQRT)
        begin
            a_op = SUB_W'({rem_reg[ROOT_W-1:0], q_reg[QUO_W-1:QUO_W-2]});
            b_op = SUB_W'({root_reg, 2'b01});
        end
        else
        begin
            a_op = SUB_W'({rem_reg[CNT_W-1:0], q_reg[QUO_W-1]});
            b_op = SUB_W'(dsr_reg);
        end
    end

    // the shared unit
    assign diff = {1'b0, a_op} - {1'b0, b_op};
    assign fits = !diff[SUB_W];

    always_ff @(posedge clk)
    begin
        priority if (go && state_reg == R_IDLE)
        begin
            q_reg   <= {dividend, {FRAC_SH{1'b0}}};
            dsr_reg <= divisor;
        end
        else if (state_reg == R_DIV)
        begin
            q_reg <= {q_reg[QUO_W-2:0], fits};
        end
        else if (state_reg == R_SQRT)
        begin
            q_reg <= {q_reg[QUO_W-3:0], 2'b00};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= R_IDLE;
            rem_reg   <= '0;
            root_reg  <= '0;
            step_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                R_IDLE:
                begin
                    done_reg <= 1'b0;
                    if (go)
                    begin
                        rem_reg   <= '0;
                        step_reg  <= '0;
                        state_reg <= R_DIV;
                    end
                end
                R_DIV:
                begin
                    done_reg <= 1'b0;
                    if (step_reg == STEP_W'(QUO_W - 1))
                    begin
                        rem_reg   <= '0;
                        root_reg  <= '0;
                        step_reg  <= '0;
                        state_reg <= R_SQRT;
                    end
                    else
                    begin
                        rem_reg  <= fits ? diff[SUB_W-1:0] : a_op;
                        step_reg <= step_reg + STEP_W'(1);
                    end
                end
                R_SQRT:
                begin
                    rem_reg  <= fits ? diff[SUB_W-1:0] : a_op;
                    root_reg <= {root_reg[ROOT_W-2:0], fits};
                    step_reg <= step_reg + STEP_W'(1);
                    done_reg <= (step_reg == STEP_W'(ROOT_W - 1));
                    if (step_reg == STEP_W'(ROOT_W - 1))
                    begin
                        state_reg <= R_IDLE;
                    end
                end
                default:
                begin
                    done_reg  <= 1'b0;
                    state_reg <= R_IDLE;
                end
            endcase
        end
    end

    assign done = done_reg;
    assign root = (root_reg > ROOT_W'({RMSSD_W{1'b1}})) ? {RMSSD_W{1'b1}}
                                                       : root_reg[RMSSD_W-1:0];

endmodule

`default_nettype wire

### rtl/hrv_rmssd_window_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Handshake          Ports
// -------   ---------          -----
// item in   start & !busy      interval_ms[11:0], window_end
// result    done (1 cycle)     rmssd_q4[15:0], status[1:0], kept_count[12:0]
// config    cfg_we             cfg_addr[0], cfg_data[11:0]
//
// An item that does not end a window keeps busy high through S_SQ and S_ADD after accept.
// A window end with an error status strobes done from S_EVAL; a valid one waits in
// S_ROOT for 44 divide steps and 22 root steps, one per cycle on
// the single shared subtractor in hrv_divsqrt.
// Reset gives min 300 ms, max 2000 ms and an empty window. There is no clearing pass.
// done is a one-cycle strobe; the receiver has no way to stall it.
module hrv_rmssd_window_unit
    import hrv_pkg::*;
#(
    parameter int unsigned MAX_INTERVALS = MAX_INTERVALS_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire logic [IV_W-1:0]       interval_ms,
    input  wire logic                  window_end,
    output logic                       done,
    output logic [RMSSD_W-1:0]         rmssd_q4,
    output logic [STATUS_W-1:0]        status,
    output logic [KEPT_W-1:0]          kept_count,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_A_W-1:0]    cfg_addr,
    input  wire logic [CFG_W-1:0]      cfg_data
);

    localparam int unsigned CNT_W = $clog2(MAX_INTERVALS + 2);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SQ,
        S_ADD,
        S_EVAL,
        S_ROOT
    } state_t;

    state_t               state_reg;
    logic                 win_end_reg;
    logic [CFG_W-1:0]     min_reg;
    logic [CFG_W-1:0]     max_reg;
    logic                 done_reg;
    logic [RMSSD_W-1:0]   rmssd_reg;
    logic [STATUS_W-1:0]  status_reg;
    logic [KEPT_W-1:0]    kept_out_reg;

    logic                 accept;
    acc_ctrl_t            acc_ctrl;
    logic [CNT_W-1:0]     kept;
    logic [SUM_W-1:0]     sum;
    logic                 overflowed;
    logic                 root_go;
    logic                 root_done;
    logic [RMSSD_W-1:0]   root;
    logic [31:0]          kept_wide;
    logic [KEPT_W-1:0]    kept_sat;

    assign busy   = (state_reg != S_IDLE);
    assign accept = start && !busy;

    assign acc_ctrl.load   = accept;
    assign acc_ctrl.square = (state_reg == S_SQ);
    assign acc_ctrl.add    = (state_reg == S_ADD);
    assign acc_ctrl.clear  = (state_reg == S_EVAL);

    assign root_go = (state_reg == S_EVAL) && !overflowed && (kept >= CNT_W'(MIN_KEPT));

    assign kept_wide = 32'(kept);
    assign kept_sat  = (kept_wide > 32'({KEPT_W{1'b1}})) ? {KEPT_W{1'b1}}
                                                         : kept_wide[KEPT_W-1:0];

    hrv_accum #(
        .MAX_INTERVALS (MAX_INTERVALS),
        .CNT_W         (CNT_W)
    ) u_accum (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (acc_ctrl),
        .interval_ms (interval_ms),
        .min_iv      (min_reg),
        .max_iv      (max_reg),
        .kept        (kept),
        .sum         (sum),
        .overflowed  (overflowed)
    );

    hrv_divsqrt #(
        .CNT_W (CNT_W)
    ) u_divsqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .go       (root_go),
        .dividend (sum),
        .divisor  (kept - CNT_W'(1)),
        .done     (root_done),
        .root     (root)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_reg <= MIN_IV_RESET;
            max_reg <= MAX_IV_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                CFG_MIN_IDX: min_reg <= cfg_data;
                CFG_MAX_IDX: max_reg <= cfg_data;
                default:     ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            win_end_reg  <= 1'b0;
            done_reg     <= 1'b0;
            rmssd_reg    <= '0;
            status_reg   <= STATUS_VALID;
            kept_out_reg <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    done_reg <= 1'b0;
                    if (accept)
                    begin
                        win_end_reg <= window_end;
                        state_reg   <= S_SQ;
                    end
                end
                S_SQ:
                begin
                    done_reg  <= 1'b0;
                    state_reg <= S_ADD;
                end
                S_ADD:
                begin
                    done_reg  <= 1'b0;
                    state_reg <= win_end_reg ? S_EVAL : S_IDLE;
                end
                S_EVAL:
                begin
                    kept_out_reg <= kept_sat;
                    rmssd_reg    <= '0;
                    priority if (overflowed)
                    begin
                        status_reg <= STATUS_OVERFLOW;
                        done_reg   <= 1'b1;
                        state_reg  <= S_IDLE;
                    end
                    else if (kept < CNT_W'(MIN_KEPT))
                    begin
                        status_reg <= STATUS_FEW;
                        done_reg   <= 1'b1;
                        state_reg  <= S_IDLE;
                    end
                    else
                    begin
                        status_reg <= STATUS_VALID;
                        done_reg   <= 1'b0;
                        state_reg  <= S_ROOT;
                    end
                end
                S_ROOT:
                begin
                    done_reg <= root_done;
                    if (root_done)
                    begin
                        rmssd_reg <= root;
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    done_reg  <= 1'b0;
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign done       = done_reg;
    assign rmssd_q4   = rmssd_reg;
    assign status     = status_reg;
    assign kept_count = kept_out_reg;

    // an error result never carries a value
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status != STATUS_VALID) |-> (rmssd_q4 == '0))
        else $error("error result with nonzero rmssd");

    // a result strobe lasts one cycle
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held longer than one cycle");

    // results come out only once the block has gone idle
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("done while busy");

    // an overflowed window always reports its saturated count
    a_ovf_count: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == STATUS_OVERFLOW) |-> (kept_count != '0))
        else $error("overflow with empty count");

    // the window is empty right after a result is formed
    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EVAL) |=> (kept == '0 && sum == '0 && !overflowed))
        else $error("window not cleared");

endmodule

`default_nettype wire
